// File: sv/vbe_pkg.sv
`timescale 1ns / 1ps
// shared constants and types for the voxel boundary extractor
package vbe_pkg;

  // configuration port
  localparam int CFG_W = 8;
  localparam int IDX_W = 2;

  localparam logic [IDX_W-1:0] REG_SIZE_X = 2'd0;
  localparam logic [IDX_W-1:0] REG_SIZE_Y = 2'd1;
  localparam logic [IDX_W-1:0] REG_SIZE_Z = 2'd2;

  localparam logic [CFG_W-1:0] SIZE_RESET = 8'd128;

  // input action codes
  localparam logic ACT_VOXEL = 1'b0;

  // running hull count
  localparam int HULL_W = 22;

  // cycles the extent products need after a size change
  localparam logic [1:0] SETTLE_CYCLES = 2'd2;

  // 3x3x3 neighborhood, indexed [outer][middle][inner], index 0 is the newest voxel
  typedef logic [2:0][2:0][2:0] cube_t;

endpackage

// File: sv/vbe_delay_line.sv
`timescale 1ns / 1ps
// variable length delay line on a single port ring memory with registered read
module vbe_delay_line #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     clr,
  input  logic [$clog2(DEPTH)-1:0] len,
  input  logic [WIDTH-1:0]         wr_data,
  output logic [WIDTH-1:0]         rd_data
);

  localparam int LEN_W = $clog2(DEPTH);

  logic [LEN_W-1:0] ptr_r, ptr_nxt;
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] mem_q_r;
  logic [WIDTH-1:0] byp_r;

  // ring pointer wraps after len entries
  always_comb begin
    ptr_nxt = ptr_r;
    if (clr) begin
      ptr_nxt = '0;
    end else if (en) begin
      if (len == '0 || ptr_r >= len - 1'b1) begin
        ptr_nxt = '0;
      end else begin
        ptr_nxt = ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
    end else begin
      ptr_r <= ptr_nxt;
    end
  end

  // read old entry and overwrite it in the same cycle
  always_ff @(posedge clk) begin
    if (en) begin
      mem[ptr_r] <= wr_data;
      mem_q_r    <= mem[ptr_r];
      byp_r      <= wr_data;
    end
  end

  // zero length means a plain one item register
  assign rd_data = (len == '0) ? byp_r : mem_q_r;

endmodule

// File: sv/vbe_window.sv
`timescale 1ns / 1ps
// plane and row buffers plus column taps that build the 3x3x3 neighborhood
module vbe_window import vbe_pkg::*; #(
  parameter int MAX_DIM = 128
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  logic                                 clr,
  input  logic                                 occ,
  input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   len_plane,
  input  logic [$clog2(MAX_DIM)-1:0]           len_row,
  output cube_t                                cube
);

  localparam int PL_DEPTH = MAX_DIM * MAX_DIM;

  logic            occ_r;
  logic [1:0]      pl_wr, pl_rd;
  logic [2:0]      col_t;
  logic [5:0]      rw_wr, rw_rd;
  logic [2:0][2:0] col_now, col1_r, col2_r;

  // newest voxel and the two older columns
  always_ff @(posedge clk) begin
    if (en) begin
      occ_r  <= occ;
      col1_r <= col_now;
      col2_r <= col1_r;
    end
  end

  // plane buffer: {s, s-plane} in, {s-plane, s-2*plane} out
  assign pl_wr = {occ_r, pl_rd[1]};

  vbe_delay_line #(
    .WIDTH (2),
    .DEPTH (PL_DEPTH)
  ) u_plane_buf (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .clr     (clr),
    .len     (len_plane),
    .wr_data (pl_wr),
    .rd_data (pl_rd)
  );

  // one voxel from each of the three planes
  assign col_t = {pl_rd[0], pl_rd[1], occ_r};

  // row buffer: {t, t-row} in, {t-row, t-2*row} out
  assign rw_wr = {col_t, rw_rd[5:3]};

  vbe_delay_line #(
    .WIDTH (6),
    .DEPTH (MAX_DIM)
  ) u_row_buf (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .clr     (clr),
    .len     (len_row),
    .wr_data (rw_wr),
    .rd_data (rw_rd)
  );

  // assemble the current column and the cube
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      col_now[a][0] = col_t[a];
      col_now[a][1] = rw_rd[3+a];
      col_now[a][2] = rw_rd[a];
      for (int b = 0; b < 3; b++) begin
        cube[a][b][0] = col_now[a][b];
        cube[a][b][1] = col1_r[a][b];
        cube[a][b][2] = col2_r[a][b];
      end
    end
  end

endmodule

// File: sv/voxel_boundary_extract_top.sv
`timescale 1ns / 1ps
// top level of the streaming voxel boundary extractor
//
// Voxels arrive on the in_ channel in raster order (outer x, middle y, inner z),
// one occupancy bit per transaction; in_action high marks a flush item that
// counts as an empty voxel. Each voxel is judged once the item one plane plus
// one row plus one voxel later has been taken, so after the grid the host sends
// that many flush items. The result for voxel p shows on the out_ channel once the
// transaction that completes its neighborhood has passed a stage register and an
// output register that sit between the channels, so one more item is taken while
// a result waits on out_ready; after that in_ready drops until the receiver takes
// the result. Throughput is one transaction per cycle while in_ready is high: one
// plane buffer and one row buffer, each a single ring memory with one read and one
// write per item, feed all 27 neighbors at once. Reset restores 128 for every
// extent and clears the position, warm-up and hull counters; the buffers are not
// cleared since only written entries are ever used. in_ready stays low after reset
// and after each size write while the plane and delay products settle. Sizes must
// be written on the cfg_ port only while idle; the block does not enforce this.
module voxel_boundary_extract_top import vbe_pkg::*; #(
  parameter int MAX_DIM = 128
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_action,
  input  logic                       in_occupied,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [$clog2(MAX_DIM)-1:0] out_pos_x,
  output logic [$clog2(MAX_DIM)-1:0] out_pos_y,
  output logic [$clog2(MAX_DIM)-1:0] out_pos_z,
  output logic                       out_is_hull,
  output logic [HULL_W-1:0]          out_hull_count,
  output logic                       out_last,
  input  logic                       cfg_we,
  input  logic [IDX_W-1:0]           cfg_index,
  input  logic [CFG_W-1:0]           cfg_wdata
);

  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int CRD_W = $clog2(MAX_DIM);
  localparam int PLN_W = $clog2(MAX_DIM * MAX_DIM + 1);
  localparam int DLY_W = $clog2(MAX_DIM * MAX_DIM + MAX_DIM + 2);
  localparam int PL_W  = $clog2(MAX_DIM * MAX_DIM);
  localparam int RL_W  = $clog2(MAX_DIM);

  function automatic logic [DIM_W-1:0] eff_size(input logic [CFG_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (32'(v) > MAX_DIM) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = DIM_W'(v);
    end
    return r;
  endfunction

  logic [CFG_W-1:0]   size_x_r, size_y_r, size_z_r;
  logic [CFG_W-1:0]   size_x_nxt, size_y_nxt, size_z_nxt;
  logic               cfg_hit;
  logic [1:0]         settle_r, settle_nxt;
  logic [DIM_W-1:0]   nx, ny, nz;
  logic [2*DIM_W-1:0] plane_full;
  logic [PLN_W-1:0]   plane_r;
  logic [DLY_W-1:0]   delay_r;
  logic [PL_W-1:0]    len_plane;
  logic [RL_W-1:0]    len_row;

  logic               in_fire, occ_in, has_res;
  logic [DLY_W-1:0]   warm_r, warm_nxt;
  logic [CRD_W-1:0]   ox_r, oy_r, oz_r, ox_nxt, oy_nxt, oz_nxt;
  logic               end_x, end_y, end_z, o_last;

  logic               s1_v_r, s1_v_nxt, s1_move;
  logic [CRD_W-1:0]   s1_x_r, s1_y_r, s1_z_r;
  logic               s1_last_r;
  cube_t              cube;
  logic [2:0]         ok_x, ok_y, ok_z;
  logic               nb_empty, hull_now;

  logic               out_valid_r, out_valid_nxt;
  logic [HULL_W-1:0]  hull_cnt_r, hull_cnt_nxt, hull_inc;

  // size registers
  always_comb begin
    size_x_nxt = size_x_r;
    size_y_nxt = size_y_r;
    size_z_nxt = size_z_r;
    cfg_hit    = 1'b0;
    if (cfg_we) begin
      case (cfg_index)
        REG_SIZE_X: begin
          size_x_nxt = cfg_wdata;
          cfg_hit    = 1'b1;
        end
        REG_SIZE_Y: begin
          size_y_nxt = cfg_wdata;
          cfg_hit    = 1'b1;
        end
        REG_SIZE_Z: begin
          size_z_nxt = cfg_wdata;
          cfg_hit    = 1'b1;
        end
        default: begin
          cfg_hit = 1'b0;
        end
      endcase
    end
  end

  // settle counter holds off input until the products are valid
  always_comb begin
    settle_nxt = settle_r;
    if (cfg_hit) begin
      settle_nxt = SETTLE_CYCLES;
    end else if (settle_r != '0) begin
      settle_nxt = settle_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r <= SIZE_RESET;
      size_y_r <= SIZE_RESET;
      size_z_r <= SIZE_RESET;
      settle_r <= SETTLE_CYCLES;
    end else begin
      size_x_r <= size_x_nxt;
      size_y_r <= size_y_nxt;
      size_z_r <= size_z_nxt;
      settle_r <= settle_nxt;
    end
  end

  // effective extents and registered plane and delay
  assign nx         = eff_size(size_x_r);
  assign ny         = eff_size(size_y_r);
  assign nz         = eff_size(size_z_r);
  assign plane_full = (2*DIM_W)'(ny) * (2*DIM_W)'(nz);

  always_ff @(posedge clk) begin
    plane_r <= PLN_W'(plane_full);
    delay_r <= DLY_W'(plane_r) + DLY_W'(nz) + DLY_W'(1);
  end

  assign len_plane = PL_W'(plane_r - 1'b1);
  assign len_row   = RL_W'(nz - 1'b1);

  // handshake
  assign s1_move  = s1_v_r && (!out_valid_r || out_ready);
  assign in_ready = (settle_r == '0) && (!s1_v_r || s1_move);
  assign in_fire  = in_valid && in_ready;
  assign occ_in   = (in_action == ACT_VOXEL) && in_occupied;
  assign has_res  = (warm_r == delay_r);

  // position of the next voxel to judge
  assign end_x  = (ox_r == CRD_W'(nx - 1'b1));
  assign end_y  = (oy_r == CRD_W'(ny - 1'b1));
  assign end_z  = (oz_r == CRD_W'(nz - 1'b1));
  assign o_last = end_x && end_y && end_z;

  always_comb begin
    warm_nxt = warm_r;
    ox_nxt   = ox_r;
    oy_nxt   = oy_r;
    oz_nxt   = oz_r;
    if (cfg_hit) begin
      warm_nxt = '0;
      ox_nxt   = '0;
      oy_nxt   = '0;
      oz_nxt   = '0;
    end else if (in_fire) begin
      if (!has_res) begin
        warm_nxt = warm_r + 1'b1;
      end else if (o_last) begin
        warm_nxt = '0;
        ox_nxt   = '0;
        oy_nxt   = '0;
        oz_nxt   = '0;
      end else if (!end_z) begin
        oz_nxt = oz_r + 1'b1;
      end else begin
        oz_nxt = '0;
        if (!end_y) begin
          oy_nxt = oy_r + 1'b1;
        end else begin
          oy_nxt = '0;
          ox_nxt = ox_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warm_r <= '0;
      ox_r   <= '0;
      oy_r   <= '0;
      oz_r   <= '0;
    end else begin
      warm_r <= warm_nxt;
      ox_r   <= ox_nxt;
      oy_r   <= oy_nxt;
      oz_r   <= oz_nxt;
    end
  end

  // neighborhood buffers
  vbe_window #(
    .MAX_DIM (MAX_DIM)
  ) u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (in_fire),
    .clr       (cfg_hit),
    .occ       (occ_in),
    .len_plane (len_plane),
    .len_row   (len_row),
    .cube      (cube)
  );

  // judge stage: coordinates of the voxel at the cube center
  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_fire) begin
      s1_v_nxt = has_res;
    end else if (s1_move) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_x_r    <= ox_r;
      s1_y_r    <= oy_r;
      s1_z_r    <= oz_r;
      s1_last_r <= o_last;
    end
  end

  // hull test: center occupied and some neighbor empty or off the grid
  always_comb begin
    ok_x[0]  = (s1_x_r != CRD_W'(nx - 1'b1));
    ok_x[1]  = 1'b1;
    ok_x[2]  = (s1_x_r != '0);
    ok_y[0]  = (s1_y_r != CRD_W'(ny - 1'b1));
    ok_y[1]  = 1'b1;
    ok_y[2]  = (s1_y_r != '0);
    ok_z[0]  = (s1_z_r != CRD_W'(nz - 1'b1));
    ok_z[1]  = 1'b1;
    ok_z[2]  = (s1_z_r != '0);
    nb_empty = 1'b0;
    for (int a = 0; a < 3; a++) begin
      for (int b = 0; b < 3; b++) begin
        for (int c = 0; c < 3; c++) begin
          if (!(a == 1 && b == 1 && c == 1)) begin
            if (!(ok_x[a] && ok_y[b] && ok_z[c] && cube[a][b][c])) begin
              nb_empty = 1'b1;
            end
          end
        end
      end
    end
    hull_now = cube[1][1][1] && nb_empty;
  end

  // saturating hull count, cleared after the last voxel
  assign hull_inc = (hull_now && hull_cnt_r != '1) ? hull_cnt_r + 1'b1 : hull_cnt_r;

  always_comb begin
    hull_cnt_nxt = hull_cnt_r;
    if (cfg_hit) begin
      hull_cnt_nxt = '0;
    end else if (s1_move) begin
      hull_cnt_nxt = s1_last_r ? '0 : hull_inc;
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_move) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      hull_cnt_r  <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      hull_cnt_r  <= hull_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_pos_x      <= s1_x_r;
      out_pos_y      <= s1_y_r;
      out_pos_z      <= s1_z_r;
      out_is_hull    <= hull_now;
      out_hull_count <= hull_inc;
      out_last       <= s1_last_r;
    end
  end

  assign out_valid = out_valid_r;

  // a size write blocks input while the products settle
  a_cfg_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_hit |=> !in_ready)
    else $error("input taken right after a size write");

  // the last voxel sits at the far corner of the grid
  a_last_at_corner: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && s1_last_r |-> (s1_x_r == CRD_W'(nx - 1'b1)) &&
      (s1_y_r == CRD_W'(ny - 1'b1)) && (s1_z_r == CRD_W'(nz - 1'b1)))
    else $error("last flag away from the grid corner");

  // a hull voxel never reports a zero count
  a_hull_counted: assert property (@(posedge clk) disable iff (!rst_n)
    s1_move && hull_now |=> out_hull_count != '0)
    else $error("hull voxel with zero count");

  // a judged voxel that cannot leave keeps its y and z position
  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !s1_move |=> s1_v_r && $stable(s1_z_r) && $stable(s1_y_r))
    else $error("judge stage changed while blocked");

endmodule
